### design/chip8ic_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chip8ic_pkg
// Shared types and opcode constants for the CHIP-8 instruction core.
// ----------------------------------------------------------------------------
package chip8ic_pkg;

  localparam int MEM_AW = 12;
  localparam logic [MEM_AW-1:0] PC_RESET  = 12'h200;
  localparam logic [15:0]       IDX_LIMIT = 16'h1000;

  localparam logic [1:0] MODE_EXEC  = 2'd0;
  localparam logic [1:0] MODE_MEMWR = 2'd1;
  localparam logic [1:0] MODE_MEMRD = 2'd2;
  localparam logic [1:0] MODE_SCRRD = 2'd3;

  localparam logic [15:0] OPC_CLS = 16'h00E0;
  localparam logic [15:0] OPC_RET = 16'h00EE;

  localparam logic [3:0] GRP_SYS  = 4'h0;
  localparam logic [3:0] GRP_JP   = 4'h1;
  localparam logic [3:0] GRP_CALL = 4'h2;
  localparam logic [3:0] GRP_SEI  = 4'h3;
  localparam logic [3:0] GRP_SNEI = 4'h4;
  localparam logic [3:0] GRP_SER  = 4'h5;
  localparam logic [3:0] GRP_LDI  = 4'h6;
  localparam logic [3:0] GRP_ADDI = 4'h7;
  localparam logic [3:0] GRP_ALU  = 4'h8;
  localparam logic [3:0] GRP_SNER = 4'h9;
  localparam logic [3:0] GRP_LDX  = 4'hA;
  localparam logic [3:0] GRP_JPO  = 4'hB;
  localparam logic [3:0] GRP_RND  = 4'hC;
  localparam logic [3:0] GRP_DRW  = 4'hD;
  localparam logic [3:0] GRP_KEY  = 4'hE;
  localparam logic [3:0] GRP_MISC = 4'hF;

  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [7:0] KEY_DOWN = 8'h9E;
  localparam logic [7:0] KEY_UP   = 8'hA1;

  localparam logic [7:0] FN_GDLY = 8'h07;
  localparam logic [7:0] FN_WKEY = 8'h0A;
  localparam logic [7:0] FN_SDLY = 8'h15;
  localparam logic [7:0] FN_SSND = 8'h18;
  localparam logic [7:0] FN_ADDI = 8'h1E;
  localparam logic [7:0] FN_FONT = 8'h29;
  localparam logic [7:0] FN_BCD  = 8'h33;
  localparam logic [7:0] FN_STOR = 8'h55;
  localparam logic [7:0] FN_LOAD = 8'h65;

  localparam logic [3:0] REG_VF = 4'hF;
  localparam logic [3:0] REG_V0 = 4'h0;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_FIN, S_MRD, S_SDIV, S_SRD, S_SOUT,
    S_F1, S_F2, S_F3, S_F4, S_F5, S_EXEC, S_WVF, S_CLS,
    S_DXM, S_DYM, S_DRD, S_DWR,
    S_B100, S_B10, S_BW0, S_BW1, S_BW2,
    S_STRD, S_STWR, S_LDRD, S_LDWR
  } state_t;

endpackage

`default_nettype wire

### design/chip8_instruction_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chip8_instruction_core
// CHIP-8 processor core with memory, screen and register file access modes.
// ----------------------------------------------------------------------------
// Usage: after reset the core sweeps memory, screen and registers to zero
// with busy high. A transfer is taken when start is high and busy is low;
// its one result appears with out_strobe for one cycle and must be taken
// then. Screen read returns zero out of range, else finds the row by
// repeated subtraction. An instruction fetches its opcode and reads its
// operands through the single read port of the memory and register file,
// with extra states for ALU flag ops (VF write), clear (row by row), draw
// (coordinate wrap, a read and write per sprite row, flag write), BCD
// (repeated subtraction, three byte writes) and block save and load (a
// read and write per register).
module chip8_instruction_core #(
  parameter int SCREEN_WIDTH  = 64,
  parameter int SCREEN_HEIGHT = 32,
  parameter int STACK_DEPTH   = 16,
  parameter int FONT_BASE     = 80
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_mode,
  input  wire logic [11:0] in_address,
  input  wire logic [7:0]  in_write_data,
  input  wire logic [15:0] in_keys_down,
  input  wire logic        in_key_press_valid,
  input  wire logic [3:0]  in_key_press_code,
  input  wire logic [7:0]  in_random_byte,
  output logic             out_strobe,
  output logic             out_status,
  output logic [7:0]       out_read_data,
  output logic [11:0]      out_program_counter,
  output logic             out_sound_on,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_original_quirks
);
  import chip8ic_pkg::*;

  localparam int XW  = $clog2(SCREEN_WIDTH);
  localparam int YW  = $clog2(SCREEN_HEIGHT);
  localparam int SPW = $clog2(STACK_DEPTH);
  localparam int RB  = SCREEN_WIDTH / 8;
  localparam int SCR_BYTES = RB * SCREEN_HEIGHT;
  localparam int MEM_DEPTH = 1 << MEM_AW;

  logic [7:0]               mem [MEM_DEPTH];
  logic [SCREEN_WIDTH-1:0]  scr [SCREEN_HEIGHT];
  logic [7:0]               rf  [16];
  logic [11:0]              stk [STACK_DEPTH];

  logic [7:0]              mem_q;
  logic [SCREEN_WIDTH-1:0] scr_q;
  logic [7:0]              rf_q;
  logic [11:0]             stk_q;

  logic                    mem_we, scr_we, rf_we, stk_we;
  logic [MEM_AW-1:0]       mem_wa, mem_ra;
  logic [7:0]              mem_wd, rf_wd;
  logic [YW-1:0]           scr_wa, scr_ra;
  logic [SCREEN_WIDTH-1:0] scr_wd;
  logic [3:0]              rf_wa, rf_ra;
  logic [11:0]             stk_wd;

  state_t state_r, state_nxt;
  logic [11:0] cnt_r, cnt_nxt;
  logic [11:0] pc_r, pc_nxt;
  logic [15:0] idx_r, idx_nxt;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic [7:0] dly_r, dly_nxt, snd_r, snd_nxt;
  logic quirk_r, quirk_nxt, strobe_r, strobe_nxt;

  logic status_r, status_nxt;
  logic [7:0] rdata_r, rdata_nxt;
  logic [15:0] op_r, op_nxt;
  logic [7:0] vx_r, vx_nxt, vy_r, vy_nxt, v0_r, v0_nxt, w_r, w_nxt;
  logic [3:0] i_r, i_nxt, d1_r, d1_nxt, d2_r, d2_nxt;
  logic [XW-1:0] x0_r, x0_nxt;
  logic [YW-1:0] y0_r, y0_nxt;
  logic hit_r, hit_nxt, flag_r, flag_nxt;
  logic [11:0] addr_r, addr_nxt;
  logic [7:0] wdata_r, wdata_nxt;
  logic [15:0] keys_r, keys_nxt;
  logic kpv_r, kpv_nxt;
  logic [3:0] kpc_r, kpc_nxt;
  logic [7:0] rnd_r, rnd_nxt;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[mem_ra];
    if (scr_we) begin
      scr[scr_wa] <= scr_wd;
    end
    scr_q <= scr[scr_ra];
    if (rf_we) begin
      rf[rf_wa] <= rf_wd;
    end
    rf_q <= rf[rf_ra];
    if (stk_we) begin
      stk[sp_r + SPW'(1)] <= stk_wd;
    end
    stk_q <= stk[sp_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      cnt_r    <= '0;
      pc_r     <= PC_RESET;
      idx_r    <= '0;
      sp_r     <= '0;
      dly_r    <= '0;
      snd_r    <= '0;
      quirk_r  <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      pc_r     <= pc_nxt;
      idx_r    <= idx_nxt;
      sp_r     <= sp_nxt;
      dly_r    <= dly_nxt;
      snd_r    <= snd_nxt;
      quirk_r  <= quirk_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    rdata_r  <= rdata_nxt;
    op_r     <= op_nxt;
    vx_r     <= vx_nxt;
    vy_r     <= vy_nxt;
    v0_r     <= v0_nxt;
    w_r      <= w_nxt;
    i_r      <= i_nxt;
    d1_r     <= d1_nxt;
    d2_r     <= d2_nxt;
    x0_r     <= x0_nxt;
    y0_r     <= y0_nxt;
    hit_r    <= hit_nxt;
    flag_r   <= flag_nxt;
    addr_r   <= addr_nxt;
    wdata_r  <= wdata_nxt;
    keys_r   <= keys_nxt;
    kpv_r    <= kpv_nxt;
    kpc_r    <= kpc_nxt;
    rnd_r    <= rnd_nxt;
  end

  logic [3:0]  op_x, op_y, op_n;
  logic [7:0]  op_nn;
  logic [11:0] op_nnn, pc2, pc4;
  logic [11:0] idx_i;
  logic [YW:0] row_y;
  logic [7:0]  sp_rev, shv, alu_src;
  logic [8:0]  alu_sum;
  logic [15:0] idx_sum;
  logic [SCREEN_WIDTH-1:0] spr_mask, scr_sh;
  logic        held;

  always_comb begin
    op_x   = op_r[11:8];
    op_y   = op_r[7:4];
    op_n   = op_r[3:0];
    op_nn  = op_r[7:0];
    op_nnn = op_r[11:0];
    pc2    = pc_r + 12'd2;
    pc4    = pc_r + 12'd4;
    idx_i  = idx_r[11:0] + {8'b0, i_r};
    row_y  = {1'b0, y0_r} + (YW+1)'(i_r);
    held   = keys_r[vx_r[3:0]];
    for (int j = 0; j < 8; j++) begin
      sp_rev[j] = mem_q[7-j];
    end
    spr_mask = SCREEN_WIDTH'(sp_rev) << x0_r;
    scr_sh   = scr_q >> XW'({addr_r[3:0], 3'b000});
    for (int j = 0; j < 8; j++) begin
      shv[7-j] = scr_sh[j];
    end
    alu_src = quirk_r ? vy_r : vx_r;
    alu_sum = {1'b0, vx_r} + {1'b0, vy_r};
    idx_sum = idx_r + {8'b0, vx_r};
  end

  always_comb begin
    state_nxt = state_r;  cnt_nxt = cnt_r;  pc_nxt = pc_r;  idx_nxt = idx_r;
    sp_nxt = sp_r;  dly_nxt = dly_r;  snd_nxt = snd_r;  quirk_nxt = quirk_r;
    strobe_nxt = 1'b0;
    status_nxt = status_r;  rdata_nxt = rdata_r;  op_nxt = op_r;
    vx_nxt = vx_r;  vy_nxt = vy_r;  v0_nxt = v0_r;  w_nxt = w_r;  i_nxt = i_r;
    d1_nxt = d1_r;  d2_nxt = d2_r;  x0_nxt = x0_r;  y0_nxt = y0_r;
    hit_nxt = hit_r;  flag_nxt = flag_r;  addr_nxt = addr_r;
    wdata_nxt = wdata_r;  keys_nxt = keys_r;  kpv_nxt = kpv_r;
    kpc_nxt = kpc_r;  rnd_nxt = rnd_r;
    mem_we = 1'b0;  mem_wa = addr_r;  mem_wd = '0;  mem_ra = pc_r;
    scr_we = 1'b0;  scr_wa = '0;  scr_wd = '0;  scr_ra = '0;
    rf_we = 1'b0;  rf_wa = op_x;  rf_wd = '0;  rf_ra = REG_V0;
    stk_we = 1'b0;  stk_wd = pc2;

    if (cfg_valid) begin
      quirk_nxt = cfg_original_quirks;
    end

    case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
        mem_wa = cnt_r;
        if (cnt_r < 12'(SCREEN_HEIGHT)) begin
          scr_we = 1'b1;
          scr_wa = cnt_r[YW-1:0];
        end
        if (cnt_r < 12'd16) begin
          rf_we = 1'b1;
          rf_wa = cnt_r[3:0];
        end
        cnt_nxt = cnt_r + 12'd1;
        if (cnt_r == 12'(MEM_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        mem_ra = in_address;
        if (start) begin
          addr_nxt  = in_address;
          wdata_nxt = in_write_data;
          keys_nxt  = in_keys_down;
          kpv_nxt   = in_key_press_valid;
          kpc_nxt   = in_key_press_code;
          rnd_nxt   = in_random_byte;
          y0_nxt    = '0;
          case (in_mode)
            MODE_EXEC: begin
              mem_ra    = pc_r;
              state_nxt = S_F1;
            end
            MODE_MEMWR: begin
              mem_we    = 1'b1;
              mem_wa    = in_address;
              mem_wd    = in_write_data;
              state_nxt = S_FIN;
            end
            MODE_MEMRD: state_nxt = S_MRD;
            MODE_SCRRD: begin
              if ({1'b0, in_address} < 13'(SCR_BYTES)) begin
                state_nxt = S_SDIV;
              end else begin
                state_nxt = S_FIN;
              end
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_FIN: begin
        strobe_nxt = 1'b1;  status_nxt = 1'b0;  rdata_nxt = '0;
        state_nxt  = S_IDLE;
      end
      S_MRD: begin
        strobe_nxt = 1'b1;  status_nxt = 1'b0;  rdata_nxt = mem_q;
        state_nxt  = S_IDLE;
      end
      S_SDIV: begin
        if (addr_r >= 12'(RB)) begin
          addr_nxt = addr_r - 12'(RB);
          y0_nxt   = y0_r + YW'(1);
        end else begin
          state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        scr_ra    = y0_r;
        state_nxt = S_SOUT;
      end
      S_SOUT: begin
        strobe_nxt = 1'b1;  status_nxt = 1'b0;  rdata_nxt = shv;
        state_nxt  = S_IDLE;
      end
      S_F1: begin
        mem_ra        = pc_r + 12'd1;
        op_nxt[15:8]  = mem_q;
        state_nxt     = S_F2;
      end
      S_F2: begin
        op_nxt[7:0] = mem_q;
        rf_ra       = op_x;
        state_nxt   = S_F3;
      end
      S_F3: begin
        vx_nxt    = rf_q;
        rf_ra     = op_y;
        state_nxt = S_F4;
      end
      S_F4: begin
        vy_nxt    = rf_q;
        rf_ra     = REG_V0;
        state_nxt = S_F5;
      end
      S_F5: begin
        v0_nxt    = rf_q;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        pc_nxt     = pc2;
        strobe_nxt = 1'b1;
        status_nxt = 1'b0;
        rdata_nxt  = '0;
        state_nxt  = S_IDLE;
        case (op_r[15:12])
          GRP_SYS: begin
            if (op_r == OPC_CLS) begin
              strobe_nxt = 1'b0;
              cnt_nxt    = '0;
              state_nxt  = S_CLS;
            end else if (op_r == OPC_RET && sp_r != '0) begin
              pc_nxt = stk_q;
              sp_nxt = sp_r - SPW'(1);
            end else begin
              status_nxt = 1'b1;
            end
          end
          GRP_JP: pc_nxt = op_nnn;
          GRP_CALL: begin
            if (sp_r >= SPW'(STACK_DEPTH - 1)) begin
              status_nxt = 1'b1;
            end else begin
              stk_we = 1'b1;
              sp_nxt = sp_r + SPW'(1);
              pc_nxt = op_nnn;
            end
          end
          GRP_SEI: if (vx_r == op_nn) pc_nxt = pc4;
          GRP_SNEI: if (vx_r != op_nn) pc_nxt = pc4;
          GRP_SER: begin
            if (op_n != 4'h0) status_nxt = 1'b1;
            else if (vx_r == vy_r) pc_nxt = pc4;
          end
          GRP_SNER: begin
            if (op_n != 4'h0) status_nxt = 1'b1;
            else if (vx_r != vy_r) pc_nxt = pc4;
          end
          GRP_LDI: begin
            rf_we = 1'b1;  rf_wd = op_nn;
          end
          GRP_ADDI: begin
            rf_we = 1'b1;  rf_wd = vx_r + op_nn;
          end
          GRP_ALU: begin
            rf_we = 1'b1;
            case (op_n)
              ALU_MOV: rf_wd = vy_r;
              ALU_OR:  rf_wd = vx_r | vy_r;
              ALU_AND: rf_wd = vx_r & vy_r;
              ALU_XOR: rf_wd = vx_r ^ vy_r;
              ALU_ADD: begin
                rf_wd = alu_sum[7:0];  flag_nxt = alu_sum[8];
              end
              ALU_SUB: begin
                rf_wd = vx_r - vy_r;  flag_nxt = vx_r >= vy_r;
              end
              ALU_SBN: begin
                rf_wd = vy_r - vx_r;  flag_nxt = vy_r >= vx_r;
              end
              ALU_SHR: begin
                rf_wd = {1'b0, alu_src[7:1]};  flag_nxt = alu_src[0];
              end
              ALU_SHL: begin
                rf_wd = {alu_src[6:0], 1'b0};  flag_nxt = alu_src[7];
              end
              default: begin
                rf_we = 1'b0;  status_nxt = 1'b1;
              end
            endcase
            if (op_n == ALU_ADD || op_n == ALU_SUB || op_n == ALU_SBN ||
                op_n == ALU_SHR || op_n == ALU_SHL) begin
              strobe_nxt = 1'b0;
              state_nxt  = S_WVF;
            end
          end
          GRP_LDX: idx_nxt = {4'b0, op_nnn};
          GRP_JPO: pc_nxt = op_nnn + {4'b0, (quirk_r ? v0_r : vx_r)};
          GRP_RND: begin
            rf_we = 1'b1;  rf_wd = op_nn & rnd_r;
          end
          GRP_DRW: begin
            strobe_nxt = 1'b0;
            w_nxt      = vx_r;
            i_nxt      = '0;
            hit_nxt    = 1'b0;
            state_nxt  = S_DXM;
          end
          GRP_KEY: begin
            if (op_nn == KEY_DOWN) begin
              if (held) pc_nxt = pc4;
            end else if (op_nn == KEY_UP) begin
              if (!held) pc_nxt = pc4;
            end else begin
              status_nxt = 1'b1;
            end
          end
          default: begin
            case (op_nn)
              FN_GDLY: begin
                rf_we = 1'b1;  rf_wd = dly_r;
              end
              FN_SDLY: dly_nxt = vx_r;
              FN_SSND: snd_nxt = vx_r;
              FN_ADDI: begin
                idx_nxt = idx_sum;
                if (idx_sum > IDX_LIMIT) begin
                  rf_we = 1'b1;  rf_wa = REG_VF;  rf_wd = 8'd1;
                end
              end
              FN_WKEY: begin
                if (kpv_r) begin
                  rf_we = 1'b1;  rf_wd = {4'b0, kpc_r};
                end else begin
                  pc_nxt = pc_r;
                end
              end
              FN_FONT: idx_nxt = 16'(FONT_BASE) + {12'b0, vx_r[3:0]} * 16'd5;
              FN_BCD: begin
                strobe_nxt = 1'b0;
                w_nxt  = vx_r;
                d1_nxt = '0;
                d2_nxt = '0;
                state_nxt = S_B100;
              end
              FN_STOR: begin
                strobe_nxt = 1'b0;  i_nxt = '0;  state_nxt = S_STRD;
              end
              FN_LOAD: begin
                strobe_nxt = 1'b0;  i_nxt = '0;  state_nxt = S_LDRD;
              end
              default: status_nxt = 1'b1;
            endcase
          end
        endcase
      end
      S_WVF: begin
        rf_we = 1'b1;  rf_wa = REG_VF;  rf_wd = {7'b0, flag_r};
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_CLS: begin
        scr_we  = 1'b1;
        scr_wa  = cnt_r[YW-1:0];
        cnt_nxt = cnt_r + 12'd1;
        if (cnt_r == 12'(SCREEN_HEIGHT - 1)) begin
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_DXM: begin
        if (w_r >= 8'(SCREEN_WIDTH)) begin
          w_nxt = w_r - 8'(SCREEN_WIDTH);
        end else begin
          x0_nxt    = w_r[XW-1:0];
          w_nxt     = vy_r;
          state_nxt = S_DYM;
        end
      end
      S_DYM: begin
        if (w_r >= 8'(SCREEN_HEIGHT)) begin
          w_nxt = w_r - 8'(SCREEN_HEIGHT);
        end else begin
          y0_nxt    = w_r[YW-1:0];
          state_nxt = S_DRD;
        end
      end
      S_DRD: begin
        if (i_r == op_n || row_y >= (YW+1)'(SCREEN_HEIGHT)) begin
          rf_we = 1'b1;  rf_wa = REG_VF;  rf_wd = {7'b0, hit_r};
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          mem_ra    = idx_i;
          scr_ra    = row_y[YW-1:0];
          state_nxt = S_DWR;
        end
      end
      S_DWR: begin
        scr_we    = 1'b1;
        scr_wa    = row_y[YW-1:0];
        scr_wd    = scr_q ^ spr_mask;
        hit_nxt   = hit_r | (|(scr_q & spr_mask));
        i_nxt     = i_r + 4'd1;
        state_nxt = S_DRD;
      end
      S_B100: begin
        if (w_r >= 8'd100) begin
          w_nxt = w_r - 8'd100;  d1_nxt = d1_r + 4'd1;
        end else begin
          state_nxt = S_B10;
        end
      end
      S_B10: begin
        if (w_r >= 8'd10) begin
          w_nxt = w_r - 8'd10;  d2_nxt = d2_r + 4'd1;
        end else begin
          state_nxt = S_BW0;
        end
      end
      S_BW0: begin
        mem_we = 1'b1;  mem_wa = idx_r[11:0];  mem_wd = {4'b0, d1_r};
        state_nxt = S_BW1;
      end
      S_BW1: begin
        mem_we = 1'b1;  mem_wa = idx_r[11:0] + 12'd1;  mem_wd = {4'b0, d2_r};
        state_nxt = S_BW2;
      end
      S_BW2: begin
        mem_we = 1'b1;  mem_wa = idx_r[11:0] + 12'd2;  mem_wd = w_r;
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_STRD: begin
        rf_ra     = i_r;
        state_nxt = S_STWR;
      end
      S_STWR: begin
        mem_we = 1'b1;  mem_wa = idx_i;  mem_wd = rf_q;
        i_nxt  = i_r + 4'd1;
        if (i_r == op_x) begin
          strobe_nxt = 1'b1;  state_nxt = S_IDLE;
        end else begin
          state_nxt = S_STRD;
        end
      end
      S_LDRD: begin
        mem_ra    = idx_i;
        state_nxt = S_LDWR;
      end
      S_LDWR: begin
        rf_we = 1'b1;  rf_wa = i_r;  rf_wd = mem_q;
        i_nxt = i_r + 4'd1;
        if (i_r == op_x) begin
          strobe_nxt = 1'b1;  state_nxt = S_IDLE;
        end else begin
          state_nxt = S_LDRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy                = (state_r != S_IDLE);
  assign cfg_ready           = 1'b1;
  assign out_strobe          = strobe_r;
  assign out_status          = status_r;
  assign out_read_data       = rdata_r;
  assign out_program_counter = pc_r;
  assign out_sound_on        = (snd_r != 8'd0);

endmodule

`default_nettype wire

### design/chip8ic_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chip8ic_checker
// Port-level timing checks for the CHIP-8 instruction core.
// ----------------------------------------------------------------------------
module chip8ic_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_strobe
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised after transfer");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy) else $error("result while busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("result repeated");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && !start |=> !busy && !out_strobe) else $error("activity without transfer");

endmodule

bind chip8_instruction_core chip8ic_checker u_chip8ic_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe)
);

`default_nettype wire

### bench/tb_chip8_instruction_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_chip8_instruction_core
// Drives memory writes, instruction steps and memory/screen reads through
// the command port, predicts every result with an internal CPU model and
// compares status, read data, program counter and sound flag per transfer.
// ----------------------------------------------------------------------------
module tb_chip8_instruction_core;
  import chip8ic_pkg::*;

  localparam int SCR_W = 64;
  localparam int SCR_H = 32;
  localparam int STK_D = 16;
  localparam int FONT_AT = 80;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic        status;
    logic [7:0]  read_data;
    logic [11:0] pc;
    logic        sound_on;
  } core_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0]  in_mode = '0;
  logic [11:0] in_address = '0;
  logic [7:0]  in_write_data = '0;
  logic [15:0] in_keys_down = '0;
  logic        in_key_press_valid = 1'b0;
  logic [3:0]  in_key_press_code = '0;
  logic [7:0]  in_random_byte = '0;
  logic out_strobe, out_status, out_sound_on;
  logic [7:0]  out_read_data;
  logic [11:0] out_program_counter;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_original_quirks = 1'b0;

  chip8_instruction_core DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_address(in_address), .in_write_data(in_write_data),
    .in_keys_down(in_keys_down), .in_key_press_valid(in_key_press_valid),
    .in_key_press_code(in_key_press_code), .in_random_byte(in_random_byte),
    .out_strobe(out_strobe), .out_status(out_status),
    .out_read_data(out_read_data), .out_program_counter(out_program_counter),
    .out_sound_on(out_sound_on), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_original_quirks(cfg_original_quirks)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [7:0]  m_mem [4096];
  logic [SCR_W-1:0] m_scr [SCR_H];   // bit SCR_W-1-x is pixel x
  logic [7:0]  m_v [16];
  logic [11:0] m_stk [STK_D];
  int          m_sp;
  logic [11:0] m_pc;
  logic [15:0] m_idx;
  logic [7:0]  m_dly, m_snd;
  logic        m_quirks;

  core_result_t expected_q[$];
  int  mismatches = 0;
  int  cycles = 0;
  bit  steady = 1'b0;   // no idling while set

  function automatic logic pix(int r, int c);
    return m_scr[r][SCR_W-1-c];
  endfunction

  function automatic logic [7:0] mrd(int a);
    return m_mem[a[11:0]];
  endfunction

  task automatic model_exec(input logic [15:0] keys, input logic kv,
                            input logic [3:0] kc, input logic [7:0] rnd,
                            output logic st);
    logic [15:0] op;
    logic [3:0] x, y, n;
    logic [7:0] nn, vx, vy, r, bits;
    logic f;
    logic [11:0] nnn;
    logic held, hit;
    int x0, y0;
    op = {mrd(m_pc), mrd(m_pc + 1)};
    x = op[11:8]; y = op[7:4]; n = op[3:0]; nn = op[7:0]; nnn = op[11:0];
    held = keys[m_v[x][3:0]];
    m_pc = m_pc + 12'd2;
    st = 1'b0;
    case (op[15:12])
      GRP_SYS: begin
        if (op == OPC_CLS) begin
          for (int i = 0; i < SCR_H; i++) m_scr[i] = '0;
        end else if (op == OPC_RET && m_sp > 0) begin
          m_pc = m_stk[m_sp];
          m_sp--;
        end else st = 1'b1;
      end
      GRP_JP: m_pc = nnn;
      GRP_CALL: begin
        if (m_sp >= STK_D - 1) st = 1'b1;
        else begin
          m_sp++;
          m_stk[m_sp] = m_pc;
          m_pc = nnn;
        end
      end
      GRP_SEI: if (m_v[x] == nn) m_pc += 12'd2;
      GRP_SNEI: if (m_v[x] != nn) m_pc += 12'd2;
      GRP_SER: begin
        if (n != 0) st = 1'b1;
        else if (m_v[x] == m_v[y]) m_pc += 12'd2;
      end
      GRP_LDI: m_v[x] = nn;
      GRP_ADDI: m_v[x] = m_v[x] + nn;
      GRP_ALU: begin
        vx = m_v[x]; vy = m_v[y];
        case (n)
          ALU_MOV: m_v[x] = vy;
          ALU_OR:  m_v[x] = vx | vy;
          ALU_AND: m_v[x] = vx & vy;
          ALU_XOR: m_v[x] = vx ^ vy;
          ALU_ADD, ALU_SUB, ALU_SBN, ALU_SHR, ALU_SHL: begin
            if (n == ALU_ADD) begin r = vx + vy; f = ({1'b0, vx} + vy) > 255; end
            else if (n == ALU_SUB) begin r = vx - vy; f = vx >= vy; end
            else if (n == ALU_SBN) begin r = vy - vx; f = vy >= vx; end
            else begin
              if (m_quirks) vx = vy;
              if (n == ALU_SHR) begin r = vx >> 1; f = vx[0]; end
              else begin r = vx << 1; f = vx[7]; end
            end
            m_v[x] = r;
            m_v[REG_VF] = {7'h0, f};
          end
          default: st = 1'b1;
        endcase
      end
      GRP_SNER: begin
        if (n != 0) st = 1'b1;
        else if (m_v[x] != m_v[y]) m_pc += 12'd2;
      end
      GRP_LDX: m_idx = {4'h0, nnn};
      GRP_JPO: m_pc = nnn + {4'h0, m_v[m_quirks ? REG_V0 : x]};
      GRP_RND: m_v[x] = nn & rnd;
      GRP_DRW: begin
        x0 = m_v[x] % SCR_W; y0 = m_v[y] % SCR_H; hit = 1'b0;
        for (int i = 0; i < n && y0 + i < SCR_H; i++) begin
          bits = mrd(m_idx + i);
          for (int j = 0; j < 8 && x0 + j < SCR_W; j++)
            if (bits[7-j]) begin
              if (pix(y0 + i, x0 + j)) hit = 1'b1;
              m_scr[y0+i][SCR_W-1-(x0+j)] = ~pix(y0 + i, x0 + j);
            end
        end
        m_v[REG_VF] = {7'h0, hit};
      end
      GRP_KEY: begin
        if (nn == KEY_DOWN) begin if (held) m_pc += 12'd2; end
        else if (nn == KEY_UP) begin if (!held) m_pc += 12'd2; end
        else st = 1'b1;
      end
      default: begin
        vx = m_v[x];
        case (nn)
          FN_GDLY: m_v[x] = m_dly;
          FN_SDLY: m_dly = vx;
          FN_SSND: m_snd = vx;
          FN_ADDI: begin
            m_idx = m_idx + {8'h0, vx};
            if (m_idx > IDX_LIMIT) m_v[REG_VF] = 8'd1;
          end
          FN_WKEY: if (kv) m_v[x] = {4'h0, kc}; else m_pc -= 12'd2;
          FN_FONT: m_idx = 16'(FONT_AT) + {12'h0, vx[3:0]} * 16'd5;
          FN_BCD: begin
            m_mem[m_idx[11:0]] = vx / 8'd100;
            m_mem[12'(m_idx + 16'd1)] = (vx / 8'd10) % 8'd10;
            m_mem[12'(m_idx + 16'd2)] = vx % 8'd10;
          end
          FN_STOR: for (int i = 0; i <= x; i++) m_mem[12'(m_idx + 16'(i))] = m_v[i];
          FN_LOAD: for (int i = 0; i <= x; i++) m_v[i] = mrd(m_idx + i);
          default: st = 1'b1;
        endcase
      end
    endcase
  endtask

  task automatic predict_core_step();
    core_result_t e;
    int row;
    e = '0;
    case (in_mode)
      MODE_EXEC: model_exec(in_keys_down, in_key_press_valid, in_key_press_code,
                            in_random_byte, e.status);
      MODE_MEMWR: m_mem[in_address] = in_write_data;
      MODE_MEMRD: e.read_data = m_mem[in_address];
      default: if (in_address < SCR_W / 8 * SCR_H) begin
        row = in_address / (SCR_W / 8);
        for (int j = 0; j < 8; j++)
          e.read_data[7-j] = pix(row, (in_address % (SCR_W / 8)) * 8 + j);
      end
    endcase
    e.pc = m_pc;
    e.sound_on = m_snd != 0;
    expected_q.push_back(e);
  endtask

  // start is held low through the idle cycles before an item
  task automatic idle_gap();
    if (!steady) begin
      while ($urandom_range(99) < 27) begin
        start <= 1'b0;
        @(negedge clk);
      end
    end
  endtask

  task automatic send_item(input logic [1:0] mode, input logic [11:0] addr,
                           input logic [7:0] wd, input logic [15:0] keys,
                           input logic kv, input logic [3:0] kc,
                           input logic [7:0] rnd);
    idle_gap();
    start <= 1'b1;
    in_mode <= mode; in_address <= addr; in_write_data <= wd;
    in_keys_down <= keys; in_key_press_valid <= kv;
    in_key_press_code <= kc; in_random_byte <= rnd;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_core_step();
    @(negedge clk);
  endtask

  task automatic poke(input logic [11:0] a, input logic [7:0] d);
    send_item(MODE_MEMWR, a, d, 16'($urandom), 1'($urandom), 4'($urandom),
              8'($urandom));
  endtask

  task automatic run_op(input logic [15:0] op);
    poke(m_pc, op[15:8]);
    poke(m_pc + 12'd1, op[7:0]);
    send_item(MODE_EXEC, 12'($urandom), 8'($urandom), 16'($urandom),
              1'($urandom), 4'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_quirks(input logic q);
    drain();
    cfg_valid <= 1'b1;
    cfg_original_quirks <= q;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    m_quirks = q;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_opcode();
    logic [15:0] op;
    op = 16'($urandom);
    case ($urandom_range(9))
      0: op = $urandom_range(1) ? OPC_CLS : OPC_RET;
      1: op[15:12] = GRP_ALU;
      2: op = {GRP_MISC, op[11:8], 4'($urandom_range(6)), op[3:0]};
      3: op = {GRP_KEY, op[11:8], $urandom_range(1) ? KEY_DOWN : KEY_UP};
      4: op = {GRP_DRW, op[11:4], 4'($urandom_range(5))};
      default: ;
    endcase
    if (op[15:12] == GRP_MISC && $urandom_range(3) != 0) begin
      case ($urandom_range(8))
        0: op[7:0] = FN_GDLY; 1: op[7:0] = FN_WKEY; 2: op[7:0] = FN_SDLY;
        3: op[7:0] = FN_SSND; 4: op[7:0] = FN_ADDI; 5: op[7:0] = FN_FONT;
        6: op[7:0] = FN_BCD;  7: op[7:0] = FN_STOR; default: op[7:0] = FN_LOAD;
      endcase
    end
    if ((op[15:12] == GRP_SER || op[15:12] == GRP_SNER) && $urandom_range(3) != 0)
      op[3:0] = 4'h0;
    return op;
  endfunction

  // results are taken on the strobe cycle; the receiver never stalls
  always @(posedge clk) begin
    core_result_t e, got;
    if (rst_n && out_strobe) begin
      got = {out_status, out_read_data, out_program_counter, out_sound_on};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        e = expected_q.pop_front();
        if (got !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%b rd=%h pc=%h snd=%b  got st=%b rd=%h pc=%h snd=%b",
                     e.status, e.read_data, e.pc, e.sound_on,
                     got.status, got.read_data, got.pc, got.sound_on);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("chip8_instruction_core: mismatch");
      $finish;
    end
  end

  task automatic test_memory_access();
    poke(12'h000, 8'hFF);
    poke(12'hFFF, 8'hA5);
    send_item(MODE_MEMRD, 12'h000, '0, '0, 1'b0, '0, '0);
    send_item(MODE_MEMRD, 12'hFFF, '0, 16'hFFFF, 1'b1, 4'hF, 8'hFF);
    send_item(MODE_SCRRD, 12'h0FF, '0, '0, 1'b0, '0, '0);
    send_item(MODE_SCRRD, 12'hFFF, '0, '0, 1'b0, '0, '0);
  endtask

  task automatic test_directed_ops();
    run_op(16'h60FF); run_op(16'h61_01); run_op(16'h8014);  // add carry
    run_op(16'h8015); run_op(16'h8017); run_op(16'h800E);   // sub, subn, shl
    run_op(16'h8016); run_op(16'h8018); run_op(16'h00EE);   // shr, illegal, empty return
    run_op(16'hA3FF); run_op(16'hD01F); run_op(16'hD010);   // draw, height 0
    run_op(16'h63FF); run_op(16'hF31E); run_op(16'hF333);   // index add, BCD
    run_op(16'hF318); run_op(16'hE19E); run_op(16'hE1A1);
    run_op(16'hF00A); run_op(16'h00E0); run_op(16'hB123);
    for (int i = 0; i < 16; i++) run_op({GRP_CALL, 12'h300 + 12'(i * 4)});
    send_item(MODE_SCRRD, 12'd0, '0, '0, 1'b0, '0, '0);
  endtask

  task automatic test_random_program(input int count);
    for (int k = 0; k < count; k++) begin
      if (k % 200 == 100) steady = 1'b1;
      if (k % 200 == 150) steady = 1'b0;
      case ($urandom_range(9))
        0: send_item(MODE_MEMWR, 12'($urandom), 8'($urandom), 16'($urandom),
                     1'($urandom), 4'($urandom), 8'($urandom));
        1: send_item(MODE_MEMRD, 12'($urandom), 8'($urandom), 16'($urandom),
                     1'($urandom), 4'($urandom), 8'($urandom));
        2: send_item(MODE_SCRRD,
                     $urandom_range(1) ? 12'($urandom_range(255)) : 12'($urandom),
                     8'($urandom), 16'($urandom), 1'($urandom), 4'($urandom),
                     8'($urandom));
        default: run_op(rand_opcode());
      endcase
    end
  endtask

  initial begin
    for (int i = 0; i < 4096; i++) m_mem[i] = '0;
    for (int i = 0; i < SCR_H; i++) m_scr[i] = '0;
    for (int i = 0; i < 16; i++) m_v[i] = '0;
    for (int i = 0; i < STK_D; i++) m_stk[i] = '0;
    m_sp = 0; m_pc = PC_RESET; m_idx = '0; m_dly = '0; m_snd = '0; m_quirks = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    test_memory_access();
    test_directed_ops();
    write_quirks(1'b1);
    run_op(16'h8126); run_op(16'h812E); run_op(16'hB100);
    test_random_program(220);
    write_quirks(1'b0);
    test_random_program(220);
    write_quirks(1'b1);
    test_random_program(200);
    drain();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("chip8_instruction_core: match");
    end else begin
      $display("chip8_instruction_core: mismatch");
    end
    $finish;
  end
endmodule

### chip8_instruction_core.f
design/chip8ic_pkg.sv
design/chip8_instruction_core.sv
design/chip8ic_checker.sv
bench/tb_chip8_instruction_core.sv
